[rtl/core/desrf_pkg.sv]
package desrf_pkg;

    localparam int NUM_ROUNDS = 16;
    localparam int ROUND_W    = $clog2(NUM_ROUNDS);
    localparam int KEY_W      = 64;
    localparam int HALF_W     = 32;
    localparam int CD_W       = 56;
    localparam int CH_W       = 28;
    localparam int SUBKEY_W   = 48;

    typedef struct packed {
        logic                valid;
        logic [HALF_W-1:0]   rhalf;
        logic [CD_W-1:0]     cd;
    } t_s1;

    typedef struct packed {
        logic                valid;
        logic [SUBKEY_W-1:0] x;
        logic [SUBKEY_W-1:0] subkey;
    } t_s2;

    localparam logic [6:0] PC1 [CD_W] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
        7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
        7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
        7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2 [SUBKEY_W] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
        6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
        6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
        6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
        6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // cumulative left rotation of C and D after each round's shift
    localparam logic [4:0] CUM_SHIFT [NUM_ROUNDS] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    localparam logic [5:0] ETAB [SUBKEY_W] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] PTAB [HALF_W] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
          4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
          4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
          4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
          4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
          4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
          4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
          4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
          4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
          4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
          4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
          4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
          4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
          4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
          4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
          4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
          4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
          4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
          4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
          4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
          4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
          4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
          4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
          4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
          4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
          4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
          4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
          4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
          4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
          4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
          4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
          4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
          4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
          4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
          4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
          4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
          4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
          4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
          4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
          4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
          4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
          4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
          4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
          4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
          4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
    };

    function automatic logic [CD_W-1:0] f_pc1(input logic [KEY_W-1:0] k);
        logic [CD_W-1:0] r;
        for (int i = 0; i < CD_W; i++) begin
            r[CD_W-1-i] = k[KEY_W - int'(PC1[i])];
        end
        return r;
    endfunction

    function automatic logic [SUBKEY_W-1:0] f_pc2(input logic [CD_W-1:0] cd);
        logic [SUBKEY_W-1:0] r;
        for (int i = 0; i < SUBKEY_W; i++) begin
            r[SUBKEY_W-1-i] = cd[CD_W - int'(PC2[i])];
        end
        return r;
    endfunction

    function automatic logic [SUBKEY_W-1:0] f_expand(input logic [HALF_W-1:0] h);
        logic [SUBKEY_W-1:0] r;
        for (int i = 0; i < SUBKEY_W; i++) begin
            r[SUBKEY_W-1-i] = h[HALF_W - int'(ETAB[i])];
        end
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] f_perm_p(input logic [HALF_W-1:0] s);
        logic [HALF_W-1:0] r;
        for (int i = 0; i < HALF_W; i++) begin
            r[HALF_W-1-i] = s[HALF_W - int'(PTAB[i])];
        end
        return r;
    endfunction

    function automatic logic [CH_W-1:0] f_rotl28(input logic [CH_W-1:0] v,
                                                 input logic [4:0] s);
        logic [2*CH_W-1:0] w;
        w = {v, v} << s;
        return w[2*CH_W-1:CH_W];
    endfunction

endpackage

[rtl/core/desrf_rot_stage.sv]
module desrf_rot_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [desrf_pkg::HALF_W-1:0]     i_rhalf,
    input  logic [desrf_pkg::ROUND_W-1:0]    i_round_index,
    input  logic [desrf_pkg::KEY_W-1:0]      i_key,
    output desrf_pkg::t_s1                   o_s1
);
    import desrf_pkg::*;

    logic [CD_W-1:0] cd0;
    logic [4:0]      shift;
    t_s1             n_s1;
    t_s1             r_s1;

    always_comb begin
        cd0              = f_pc1(i_key);
        shift            = CUM_SHIFT[i_round_index];
        n_s1.valid       = i_valid;
        n_s1.rhalf       = i_rhalf;
        n_s1.cd          = {f_rotl28(cd0[CD_W-1:CH_W], shift),
                            f_rotl28(cd0[CH_W-1:0], shift)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

[rtl/core/desrf_mix_stage.sv]
module desrf_mix_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  desrf_pkg::t_s1 i_s1,
    output desrf_pkg::t_s2 o_s2
);
    import desrf_pkg::*;

    t_s2 n_s2;
    t_s2 r_s2;

    always_comb begin
        n_s2.valid  = i_s1.valid;
        n_s2.subkey = f_pc2(i_s1.cd);
        n_s2.x      = f_expand(i_s1.rhalf) ^ n_s2.subkey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

[rtl/core/desrf_sub_stage.sv]
module desrf_sub_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  desrf_pkg::t_s2                   i_s2,
    output logic                             o_valid,
    output logic [desrf_pkg::HALF_W-1:0]     o_f_result,
    output logic [desrf_pkg::SUBKEY_W-1:0]   o_round_subkey
);
    import desrf_pkg::*;

    logic [HALF_W-1:0]   s_out;
    logic [5:0]          chunk;
    logic                r_valid;
    logic [HALF_W-1:0]   r_f_result;
    logic [HALF_W-1:0]   n_f_result;
    logic [SUBKEY_W-1:0] r_round_subkey;

    always_comb begin
        s_out = '0;
        chunk = '0;
        for (int j = 0; j < 8; j++) begin
            chunk = i_s2.x[SUBKEY_W-1-6*j -: 6];
            s_out[HALF_W-1-4*j -: 4] = SBOX[j][{chunk[5], chunk[0], chunk[4:1]}];
        end
        n_f_result = f_perm_p(s_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_result     <= n_f_result;
        r_round_subkey <= i_s2.subkey;
    end

    assign o_valid        = r_valid;
    assign o_f_result     = r_f_result;
    assign o_round_subkey = r_round_subkey;

endmodule

[rtl/core/des_round_function_with_key_schedule_unit.sv]
// An accepted item passes the rot, mix and sub stage registers before the o_valid strobe.
// Throughput: one item per cycle; busy is low whenever reset is released.
// Stages: key rotation, PC-2 / E / key XOR, S-boxes and P into the output register.
// Reset: synchronous active low; clears the pipeline valid bits and the key to zero.
// The receiver cannot stall; each result shows for exactly one cycle.
module des_round_function_with_key_schedule_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [desrf_pkg::HALF_W-1:0]     i_rhalf,
    input  logic [desrf_pkg::ROUND_W-1:0]    i_round_index,
    input  logic                             i_cfg_we,
    input  logic [desrf_pkg::KEY_W-1:0]      i_cfg_wdata,
    output logic                             o_valid,
    output logic [desrf_pkg::HALF_W-1:0]     o_f_result,
    output logic [desrf_pkg::SUBKEY_W-1:0]   o_round_subkey
);
    import desrf_pkg::*;

    logic [KEY_W-1:0] r_des_key;
    logic             accept;
    t_s1              s1;
    t_s2              s2;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_des_key <= '0;
        end else if (i_cfg_we) begin
            r_des_key <= i_cfg_wdata;
        end
    end

    desrf_rot_stage u_rot (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_rhalf       (i_rhalf),
        .i_round_index (i_round_index),
        .i_key         (r_des_key),
        .o_s1          (s1)
    );

    desrf_mix_stage u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    desrf_sub_stage u_sub (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s2           (s2),
        .o_valid        (o_valid),
        .o_f_result     (o_f_result),
        .o_round_subkey (o_round_subkey)
    );

endmodule

[rtl/core/desrf_checker.sv]
module desrf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    a_accept_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid
    ) else $error("accepted item produced no result after 3 cycles");

    a_result_has_item: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3)
    ) else $error("result strobe without an item accepted 3 cycles earlier");

    a_reset_clears_valid: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_valid
    ) else $error("result strobe right after reset");

    a_busy_only_in_reset: assert property (
        @(posedge i_clk)
        busy |-> !i_rst_n
    ) else $error("busy raised outside reset");

endmodule

bind des_round_function_with_key_schedule_unit desrf_checker u_desrf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
